>>> rtl/wsenc_pkg.sv
package wsenc_pkg;

  localparam logic [15:0] ShortLenMax = 16'd125;
  localparam logic [6:0]  Ext16Code   = 7'd126;
  localparam logic [7:0]  FinBit      = 8'h80;
  localparam logic [7:0]  OpcodeText  = 8'h01;
  localparam logic [7:0]  FrameHead   = FinBit | OpcodeText;

  localparam int unsigned QueueDepthDef = 4;

  typedef enum logic {
    CmdStart   = 1'b0,
    CmdPayload = 1'b1
  } cmd_e;

  // One queued job: a whole header (2..8 bytes, first byte in the top lane)
  // or a single payload byte in the top lane.
  typedef struct packed {
    logic        is_hdr;
    logic [2:0]  last_idx;
    logic        last;
    logic [63:0] bytes;
  } queue_entry_t;

endpackage

>>> rtl/wsenc_in_if.sv
interface wsenc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] payload_length;
  logic        mask_enable;
  logic [31:0] mask_key;
  logic [7:0]  data_byte;

  modport source (
    output valid, command, payload_length, mask_enable, mask_key, data_byte,
    input  ready
  );
  modport sink (
    input  valid, command, payload_length, mask_enable, mask_key, data_byte,
    output ready
  );
endinterface

>>> rtl/wsenc_out_if.sv
interface wsenc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_header;
  logic       last;

  modport source (
    output valid, out_byte, is_header, last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, is_header, last,
    output ready
  );
endinterface

>>> rtl/wsenc_front.sv
module wsenc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  wsenc_in_if.sink                in_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output wsenc_pkg::queue_entry_t q_entry_o
);

  logic        frame_open_q, frame_open_d;
  logic [15:0] remaining_q, remaining_d;
  logic [1:0]  key_idx_q, key_idx_d;
  logic [31:0] held_key_q, held_key_d;
  logic        masking_q, masking_d;

  logic        accept;
  logic        is_start;
  logic        short_len;
  logic [7:0]  key_byte;
  logic        pay_last;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign is_start   = (wsenc_pkg::cmd_e'(in_i.command) == wsenc_pkg::CmdStart);
  assign short_len  = (in_i.payload_length <= wsenc_pkg::ShortLenMax);
  assign pay_last   = (remaining_q == 16'd1);

  always_comb begin
    unique case (key_idx_q)
      2'd0:    key_byte = held_key_q[31:24];
      2'd1:    key_byte = held_key_q[23:16];
      2'd2:    key_byte = held_key_q[15:8];
      default: key_byte = held_key_q[7:0];
    endcase
  end

  always_comb begin
    frame_open_d = frame_open_q;
    remaining_d  = remaining_q;
    key_idx_d    = key_idx_q;
    held_key_d   = held_key_q;
    masking_d    = masking_q;
    q_push_o     = 1'b0;
    q_entry_o    = '0;
    if (is_start) begin
      q_entry_o.is_hdr = 1'b1;
      q_entry_o.last   = (in_i.payload_length == 16'd0);
      priority if (short_len && !in_i.mask_enable) begin
        q_entry_o.last_idx = 3'd1;
        q_entry_o.bytes    = {wsenc_pkg::FrameHead, 1'b0, in_i.payload_length[6:0], 48'd0};
      end else if (short_len) begin
        q_entry_o.last_idx = 3'd5;
        q_entry_o.bytes    = {wsenc_pkg::FrameHead, 1'b1, in_i.payload_length[6:0],
                              in_i.mask_key, 16'd0};
      end else if (!in_i.mask_enable) begin
        q_entry_o.last_idx = 3'd3;
        q_entry_o.bytes    = {wsenc_pkg::FrameHead, 1'b0, wsenc_pkg::Ext16Code,
                              in_i.payload_length, 32'd0};
      end else begin
        q_entry_o.last_idx = 3'd7;
        q_entry_o.bytes    = {wsenc_pkg::FrameHead, 1'b1, wsenc_pkg::Ext16Code,
                              in_i.payload_length, in_i.mask_key};
      end
      if (accept) begin
        q_push_o     = 1'b1;
        frame_open_d = (in_i.payload_length != 16'd0);
        remaining_d  = in_i.payload_length;
        key_idx_d    = 2'd0;
        held_key_d   = in_i.mask_key;
        masking_d    = in_i.mask_enable;
      end
    end else begin
      q_entry_o.is_hdr   = 1'b0;
      q_entry_o.last_idx = 3'd0;
      q_entry_o.last     = pay_last;
      q_entry_o.bytes    = {in_i.data_byte ^ (masking_q ? key_byte : 8'd0), 56'd0};
      if (accept && frame_open_q) begin
        q_push_o    = 1'b1;
        key_idx_d   = key_idx_q + 2'd1;
        remaining_d = remaining_q - 16'd1;
        if (pay_last) begin
          frame_open_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      remaining_q  <= '0;
      key_idx_q    <= '0;
      held_key_q   <= '0;
      masking_q    <= 1'b0;
    end else begin
      frame_open_q <= frame_open_d;
      remaining_q  <= remaining_d;
      key_idx_q    <= key_idx_d;
      held_key_q   <= held_key_d;
      masking_q    <= masking_d;
    end
  end

endmodule

>>> rtl/wsenc_queue.sv
module wsenc_queue #(
  parameter int unsigned Depth = wsenc_pkg::QueueDepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  wsenc_pkg::queue_entry_t wdata_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output wsenc_pkg::queue_entry_t rdata_o,
  output logic                    empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wsenc_pkg::queue_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/wsenc_back.sv
module wsenc_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wsenc_pkg::queue_entry_t head_i,
  input  logic                    empty_i,
  output logic                    pop_o,
  wsenc_out_if.source             out_o
);

  logic [2:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       hdr_q, hdr_d;
  logic       last_q, last_d;
  logic       emit;
  logic       at_end;

  assign emit   = !empty_i && (!valid_q || out_o.ready);
  assign at_end = (idx_q == head_i.last_idx);
  assign pop_o  = emit && at_end;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    hdr_d   = hdr_q;
    last_d  = last_q;
    if (emit) begin
      valid_d = 1'b1;
      byte_d  = head_i.bytes[63 - 8 * idx_q -: 8];
      hdr_d   = head_i.is_hdr;
      last_d  = head_i.last && at_end;
      idx_d   = at_end ? 3'd0 : idx_q + 3'd1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    hdr_q  <= hdr_d;
    last_q <= last_d;
  end

  assign out_o.valid     = valid_q;
  assign out_o.out_byte  = byte_q;
  assign out_o.is_header = hdr_q;
  assign out_o.last      = last_q;

endmodule

>>> rtl/websocket_text_frame_encoder_top.sv
// WebSocket text frame encoder (single unfragmented frame, FIN=1, text opcode).
// in_i (valid/ready): command 0 starts a frame with payload_length, mask_enable
// and mask_key; command 1 brings one data_byte. A payload item with no open
// frame is taken and dropped.
// out_o (valid/ready): one frame byte per item, with is_header and last.
// A start yields 2, 4, 6 or 8 header bytes; last marks the final header byte
// of a zero-length frame, else the final payload byte.
// An accepted item is written into the queue, then its bytes are registered
// in the output stage. Throughput: one payload byte per cycle while the receiver
// is ready; the output stage emits a header one byte at a time. A queue of
// QueueDepth items between the accepting front and the emitting back absorbs
// header bursts, so input keeps flowing while a header drains.
// Receiver stall: the output register holds its item; when the queue fills,
// in_i.ready drops.
// Reset: frame state, queue and output valid are cleared; no frame is open.
module websocket_text_frame_encoder_top #(
  parameter int unsigned QueueDepth = wsenc_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsenc_in_if.sink    in_i,
  wsenc_out_if.source out_o
);

  wsenc_pkg::queue_entry_t push_entry;
  wsenc_pkg::queue_entry_t head_entry;
  logic push, full, pop, empty;

  wsenc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_full_i  (full),
    .q_push_o  (push),
    .q_entry_o (push_entry)
  );

  wsenc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .empty_o (empty)
  );

  wsenc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> test/tb_websocket_text_frame_encoder_top.sv
`timescale 1ns / 100ps

module tb_websocket_text_frame_encoder_top;

  localparam logic [7:0] MaskBit = 8'h80;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       is_header;
    logic       last;
  } frame_byte_t;

  logic clk_i;
  logic rst_ni;

  wsenc_in_if  in_if ();
  wsenc_out_if out_if ();

  websocket_text_frame_encoder_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // encoder state as predicted
  logic        enc_open;
  logic [15:0] enc_remaining;
  logic [1:0]  enc_key_idx;
  logic [31:0] enc_key;
  logic        enc_masking;

  frame_byte_t expected_bytes[$];

  int unsigned in_idle_pct    = 29;
  int unsigned out_idle_pct   = 29;
  int unsigned error_count    = 0;
  int unsigned bytes_checked  = 0;
  int unsigned frames_started = 0;
  int unsigned random_items   = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // works out the wire bytes that one accepted item produces
  function automatic void encode_item(wsenc_pkg::cmd_e cmd, logic [15:0] len, logic men,
                                      logic [31:0] key, logic [7:0] data);
    logic [7:0]  hdr [8];
    int          n;
    frame_byte_t fb;
    if (cmd == wsenc_pkg::CmdStart) begin
      hdr[0] = wsenc_pkg::FrameHead;
      if (len <= wsenc_pkg::ShortLenMax) begin
        hdr[1] = (men ? MaskBit : 8'h00) | len[7:0];
        n = 2;
      end else begin
        hdr[1] = (men ? MaskBit : 8'h00) | {1'b0, wsenc_pkg::Ext16Code};
        hdr[2] = len[15:8];
        hdr[3] = len[7:0];
        n = 4;
      end
      if (men) begin
        for (int i = 0; i < 4; i++) hdr[n + i] = key[31 - 8 * i -: 8];
        n = n + 4;
      end
      for (int i = 0; i < n; i++) begin
        fb.wire_byte = hdr[i];
        fb.is_header = 1'b1;
        fb.last      = (len == 16'd0) && (i == n - 1);
        expected_bytes.push_back(fb);
      end
      enc_open      = (len != 16'd0);
      enc_remaining = len;
      enc_key_idx   = 2'd0;
      enc_key       = key;
      enc_masking   = men;
      frames_started++;
    end else if (enc_open) begin
      fb.wire_byte = data;
      if (enc_masking) fb.wire_byte = data ^ enc_key[31 - 8 * int'(enc_key_idx) -: 8];
      enc_key_idx   = enc_key_idx + 2'd1;
      enc_remaining = enc_remaining - 16'd1;
      fb.is_header  = 1'b0;
      fb.last       = (enc_remaining == 16'd0);
      if (fb.last) enc_open = 1'b0;
      expected_bytes.push_back(fb);
    end
  endfunction

  always @(posedge clk_i) begin : frame_checker
    frame_byte_t got;
    frame_byte_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        encode_item(wsenc_pkg::cmd_e'(in_if.command), in_if.payload_length,
                    in_if.mask_enable, in_if.mask_key, in_if.data_byte);
      end
      if (out_if.valid && out_if.ready) begin
        got.wire_byte = out_if.out_byte;
        got.is_header = out_if.is_header;
        got.last      = out_if.last;
        if (expected_bytes.size() == 0) begin
          if (error_count < MaxReports)
            $display("%0t: unexpected byte %h hdr=%b last=%b", $realtime,
                     got.wire_byte, got.is_header, got.last);
          error_count++;
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (got.wire_byte !== want.wire_byte || got.is_header !== want.is_header ||
              got.last !== want.last) begin
            if (error_count < MaxReports)
              $display("%0t: byte %0d expected %h hdr=%b last=%b, got %h hdr=%b last=%b",
                       $realtime, bytes_checked, want.wire_byte, want.is_header, want.last,
                       got.wire_byte, got.is_header, got.last);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_item(wsenc_pkg::cmd_e cmd, logic [15:0] len, logic men,
                           logic [31:0] key, logic [7:0] data);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.command        <= cmd;
    in_if.payload_length <= len;
    in_if.mask_enable    <= men;
    in_if.mask_key       <= key;
    in_if.data_byte      <= data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // unused fields carry junk
  task automatic send_start(logic [15:0] len, logic men, logic [31:0] key);
    send_item(wsenc_pkg::CmdStart, len, men, key, 8'($urandom_range(255)));
  endtask

  task automatic send_byte(logic [7:0] data);
    send_item(wsenc_pkg::CmdPayload, 16'($urandom_range(65535)), 1'($urandom_range(1)),
              $urandom, data);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_bytes.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_byte(8'hFF);                          // no frame open: dropped
    send_start(16'd0, 1'b0, 32'h0000_0000);    // zero length
    send_start(16'd0, 1'b1, 32'h0000_0000);    // zero length, masked, zero key
    send_start(16'd1, 1'b1, 32'hFFFF_FFFF);
    send_byte(8'h00);
    send_start(16'd125, 1'b1, 32'h0000_0000);  // longest short length, abandoned
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_start(16'd126, 1'b0, 32'hFFFF_FFFF);  // shortest extended length, abandoned
    send_byte(8'h00);
    send_start(16'hFFFF, 1'b1, 32'h8000_0001);
    send_byte(8'hFF);
    send_start(16'd5, 1'b1, 32'h0102_0304);    // key wraps after four bytes
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h55);
    send_byte(8'h33);                          // frame closed: dropped
    send_start(16'd2, 1'b0, 32'h0000_0000);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_extended_frame();
    wait_drained();
    send_start(16'd126, 1'b1, $urandom);
    repeat (20) send_byte(8'($urandom_range(255)));
  endtask

  task automatic random_frame();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 10) begin
      len = $urandom_range(3, 1);
      repeat (len) send_byte(8'($urandom_range(255)));
      random_items += len;
    end else if (pick < 25) begin
      // long frame cut short by the next start
      len = $urandom_range(4);
      send_start(16'($urandom_range(65535, 126)), 1'($urandom_range(1)), $urandom);
      repeat (len) send_byte(8'($urandom_range(255)));
      random_items += len + 1;
    end else begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(9);
      send_start(16'(len), 1'($urandom_range(1)),
                 ($urandom_range(7) == 0) ? 32'h0000_0000 : $urandom);
      repeat (len) send_byte(8'($urandom_range(255)));
      random_items += len + 1;
    end
  endtask

  task automatic test_random_stalls(int unsigned count);
    int unsigned stop_at;
    stop_at      = random_items + count;
    in_idle_pct  = 29;
    out_idle_pct = 29;
    while (random_items < stop_at) random_frame();
  endtask

  task automatic test_random_back_to_back(int unsigned count);
    int unsigned stop_at;
    stop_at      = random_items + count;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    while (random_items < stop_at) random_frame();
    in_idle_pct  = 29;
    out_idle_pct = 29;
  endtask

  initial begin
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.command        = 1'b0;
    in_if.payload_length = 16'd0;
    in_if.mask_enable    = 1'b0;
    in_if.mask_key       = 32'd0;
    in_if.data_byte      = 8'd0;
    enc_open             = 1'b0;
    enc_remaining        = 16'd0;
    enc_key_idx          = 2'd0;
    enc_key              = 32'd0;
    enc_masking          = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_extended_frame();
    test_random_stalls(50);
    test_random_back_to_back(25);

    wait_drained();
    repeat (20) @(negedge clk_i);

    $display("Checked %0d frame bytes from %0d frame starts: edge cases, an extended-length",
             bytes_checked, frames_started);
    $display("frame cut short, random frames with stalls and back to back.");
    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/wsenc_pkg.sv
rtl/wsenc_in_if.sv
rtl/wsenc_out_if.sv
rtl/wsenc_front.sv
rtl/wsenc_queue.sv
rtl/wsenc_back.sv
rtl/websocket_text_frame_encoder_top.sv
test/tb_websocket_text_frame_encoder_top.sv
